FILE: hdl/vector_refract_unit_defines.svh
// Assertion macros for the vector refract unit.
// Used by RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef VECTOR_REFRACT_UNIT_DEFINES_SVH
`define VECTOR_REFRACT_UNIT_DEFINES_SVH
`ifndef SYNTH
`define VRU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vru check failed");
`define VRU_NEVER(lbl, expr) `VRU_ASSERT(lbl, !(expr))
`else
`define VRU_ASSERT(lbl, prop)
`define VRU_NEVER(lbl, expr)
`endif
`endif

FILE: hdl/vru_pkg.sv
// Shared widths, stage payload types and the square root step for the refract unit.
// No dependencies.
`default_nettype none
package vru_pkg;

  localparam int F        = 15;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 19;
  localparam int RAD_W    = 38;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int ROOT_TOP = RAD_W - 2;
  localparam int COEFA_W  = 21;
  localparam int COEF_W   = COEFA_W + 1;
  localparam int TDATA_IN_W  = 7 * IN_W;
  localparam int TDATA_OUT_W = 64;

  typedef logic signed [IN_W-1:0]  comp_t;
  typedef logic signed [OUT_W-1:0] ocomp_t;

  typedef struct packed {
    comp_t [2:0]     li;
    comp_t [2:0]     nv;
    logic [IN_W-1:0] eta;
  } ray_t;

  typedef struct packed {
    ray_t                      ray;
    logic signed [COEFA_W-1:0] coefa;
    logic [RAD_W-1:0]          rad;
    logic                      tir;
  } front_t;

  typedef struct packed {
    ray_t                      ray;
    logic signed [COEFA_W-1:0] coefa;
    logic [ROOT_W-1:0]         root;
    logic                      tir;
  } root_t;

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] res;
  } rad_t;

  function automatic rad_t root_step(rad_t a, int unsigned sh);
    logic [RAD_W-1:0] b;
    logic [RAD_W-1:0] t;
    rad_t r;
    b = RAD_W'(1) << sh;
    t = a.res + b;
    if (a.rem >= t) begin
      r.rem = a.rem - t;
      r.res = (a.res >> 1) + b;
    end else begin
      r.rem = a.rem;
      r.res = a.res >> 1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/vru_front.sv
// Front pipeline: dot product, 1 - d^2, eta^2, k and the eta*d term (4 stages).
// Depends on vru_pkg.
`default_nettype none
module vru_front import vru_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire ray_t   in_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output front_t      out_data_o
);

  logic [3:0] v_q;
  logic [4:0] rdy;

  always_comb begin
    rdy[4] = out_ready_i;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = rdy[i+1] | ~v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < 4; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // stage 1: products
  ray_t               r1_q;
  logic signed [31:0] pl1_q [3];
  logic [31:0]        ee1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      r1_q  <= in_data_i;
      ee1_q <= in_data_i.eta * in_data_i.eta;
      for (int c = 0; c < 3; c++) begin
        pl1_q[c] <= in_data_i.li[c] * in_data_i.nv[c];
      end
    end
  end

  // stage 2: d and e2
  logic signed [33:0] dot;
  logic signed [33:0] dot_r;
  logic [32:0]        ee_r;
  ray_t               r2_q;
  logic signed [17:0] d2_q;
  logic [19:0]        e2_q;

  always_comb begin
    dot   = 34'(pl1_q[0]) + 34'(pl1_q[1]) + 34'(pl1_q[2]);
    dot_r = (dot + $signed(34'(1) << (F - 1))) >>> F;
    ee_r  = (33'(ee1_q) + (33'(1) << (F - 3))) >> (F - 2);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      r2_q <= r1_q;
      d2_q <= dot_r[17:0];
      e2_q <= ee_r[19:0];
    end
  end

  // stage 3: 1 - d^2 and eta*d
  logic signed [35:0]        dd;
  logic signed [36:0]        omx;
  logic signed [34:0]        etad;
  logic signed [34:0]        etad_r;
  ray_t                      r3_q;
  logic signed [20:0]        om3_q;
  logic [19:0]               e23_q;
  logic signed [COEFA_W-1:0] ca3_q;

  always_comb begin
    dd     = d2_q * d2_q;
    omx    = ($signed(37'(1) << (2 * F)) - 37'(dd) + $signed(37'(1) << (F - 1))) >>> F;
    etad   = $signed({1'b0, r2_q.eta}) * d2_q;
    etad_r = (etad + $signed(35'(1) << (F - 2))) >>> (F - 1);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      r3_q  <= r2_q;
      om3_q <= omx[20:0];
      e23_q <= e2_q;
      ca3_q <= etad_r[COEFA_W-1:0];
    end
  end

  // stage 4: k = 1 - e2*om
  logic signed [41:0] prod;
  logic signed [41:0] kx;
  front_t             f4_q;

  always_comb begin
    prod = $signed({1'b0, e23_q}) * om3_q;
    kx   = $signed(42'(1) << (2 * F)) - prod;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      f4_q.ray   <= r3_q;
      f4_q.coefa <= ca3_q;
      f4_q.tir   <= kx[41];
      f4_q.rad   <= kx[41] ? '0 : kx[RAD_W-1:0];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[3];
  assign out_data_o  = f4_q;

endmodule
`default_nettype wire

FILE: hdl/vru_sqrt.sv
// Square root pipeline: restoring bit-pair root of k, 19 steps over 3 stages.
// Depends on vru_pkg.
`default_nettype none
module vru_sqrt import vru_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire front_t in_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output root_t       out_data_o
);

  localparam int S0 = 7;
  localparam int S1 = 6;
  localparam int S2 = ROOT_W - S0 - S1;

  logic [2:0] v_q;
  logic [3:0] rdy;

  always_comb begin
    rdy[3] = out_ready_i;
    for (int i = 2; i >= 0; i--) begin
      rdy[i] = rdy[i+1] | ~v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < 3; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  rad_t   a0, a1, a2;
  front_t f0_q, f1_q;
  rad_t   rd0_q, rd1_q;
  root_t  o2_q;

  always_comb begin
    a0.rem = in_data_i.rad;
    a0.res = '0;
    for (int j = 0; j < S0; j++) begin
      a0 = root_step(a0, ROOT_TOP - 2 * j);
    end
    a1 = rd0_q;
    for (int j = S0; j < S0 + S1; j++) begin
      a1 = root_step(a1, ROOT_TOP - 2 * j);
    end
    a2 = rd1_q;
    for (int j = S0 + S1; j < S0 + S1 + S2; j++) begin
      a2 = root_step(a2, ROOT_TOP - 2 * j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      f0_q  <= in_data_i;
      rd0_q <= a0;
    end
    if (rdy[1]) begin
      f1_q  <= f0_q;
      rd1_q <= a1;
    end
    if (rdy[2]) begin
      o2_q.ray   <= f1_q.ray;
      o2_q.coefa <= f1_q.coefa;
      o2_q.tir   <= f1_q.tir;
      o2_q.root  <= a2.res[ROOT_W-1:0];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[2];
  assign out_data_o  = o2_q;

endmodule
`default_nettype wire

FILE: hdl/vru_back.sv
// Back pipeline: eta*I - coef*N, rounding and saturation to Q4.15 (2 stages).
// Depends on vru_pkg.
`default_nettype none
module vru_back import vru_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire root_t  in_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output ocomp_t [2:0] out_vec_o,
  output logic        out_tir_o
);

  logic [1:0] v_q;
  logic [2:0] rdy;

  always_comb begin
    rdy[2] = out_ready_i;
    for (int i = 1; i >= 0; i--) begin
      rdy[i] = rdy[i+1] | ~v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  // stage 1: products
  logic signed [COEF_W-1:0] coef;
  logic signed [32:0]       eli1_q [3];
  logic signed [37:0]       cn1_q  [3];
  logic                     tir1_q;

  assign coef = COEF_W'(in_data_i.coefa) + $signed({3'b0, in_data_i.root});

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      tir1_q <= in_data_i.tir;
      for (int c = 0; c < 3; c++) begin
        eli1_q[c] <= $signed({1'b0, in_data_i.ray.eta}) * in_data_i.ray.li[c];
        cn1_q[c]  <= coef * in_data_i.ray.nv[c];
      end
    end
  end

  // stage 2: difference, round, saturate
  logic signed [38:0] v    [3];
  logic signed [38:0] vr   [3];
  ocomp_t [2:0]       vec;
  ocomp_t [2:0]       vec2_q;
  logic               tir2_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v[c]  = 39'($signed({eli1_q[c], 1'b0})) - 39'(cn1_q[c]);
      vr[c] = (v[c] + $signed(39'(1) << (F - 1))) >>> F;
      if (tir1_q) begin
        vec[c] = '0;
      end else if (vr[c][38:OUT_W-1] == '0 || vr[c][38:OUT_W-1] == '1) begin
        vec[c] = vr[c][OUT_W-1:0];
      end else begin
        vec[c] = vr[c][38] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      vec2_q <= vec;
      tir2_q <= tir1_q;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[1];
  assign out_vec_o   = vec2_q;
  assign out_tir_o   = tir2_q;

endmodule
`default_nettype wire

FILE: hdl/vector_refract_unit.sv
// Vector refract unit: GLSL-style refract() on Q1.15 vectors, 9-stage pipeline.
// Depends on vru_pkg, vru_front, vru_sqrt, vru_back and the defines header.
//
// Usage:
//   Slave stream s_axis carries one ray per beat: incident vector, normal and
//   the Q2.14 index ratio. Master stream m_axis returns the refracted vector
//   in Q4.15 (saturated), with tuser set on total internal reflection, where
//   the vector is zero.
//   Throughput: one beat per cycle while m_axis_tready is high; the square
//   root runs as a 19-step bit-pair root split over 3 of the 9 stages.
//   Each stage carries a valid bit; ready flows back stage by stage, so
//   empty stages fill while the output is stalled. Input tready drops only
//   once all 9 stages hold data and m_axis_tready is low. Nothing is lost
//   or repeated across a stall.
//   Reset clears all valid bits; the data registers are not reset.
`default_nettype none
`include "vector_refract_unit_defines.svh"
module vector_refract_unit import vru_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // light_x, light_y, light_z, normal_x, normal_y, normal_z, index_ratio
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // out_x, out_y, out_z, zero pad
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata,
  // total_reflection
  output logic                        m_axis_tuser
);

  ray_t         ray;
  front_t       front;
  root_t        rootd;
  logic         f_valid, f_ready, s_valid, s_ready;
  ocomp_t [2:0] vec;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ray.li[c] = s_axis_tdata[c*IN_W +: IN_W];
      ray.nv[c] = s_axis_tdata[(c+3)*IN_W +: IN_W];
    end
    ray.eta = s_axis_tdata[6*IN_W +: IN_W];
  end

  vru_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (ray),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (front)
  );

  vru_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (front),
    .out_valid_o (s_valid),
    .out_ready_i (s_ready),
    .out_data_o  (rootd)
  );

  vru_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_valid),
    .in_ready_o  (s_ready),
    .in_data_i   (rootd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_vec_o   (vec),
    .out_tir_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {{(TDATA_OUT_W - 3 * OUT_W){1'b0}}, vec[2], vec[1], vec[0]};

  `VRU_ASSERT(a_tir_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
  `VRU_ASSERT(a_stall_full, !s_axis_tready |-> m_axis_tvalid)
  `VRU_ASSERT(a_drain_open, m_axis_tready |-> s_axis_tready)

endmodule
`default_nettype wire
